@@ src/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OSN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define OSN_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define OSN_ASSERT(lbl, clk, rst_n, prop)
`define OSN_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

@@ src/osn_pkg.sv @@
package osn_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int WAVE_WIDTH_DEF = 24;
  localparam int VISC_W = 32;
  localparam int GPC_W = 31;
  localparam int DEN_W = VISC_W + GPC_W;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int WAVE_FRAC = 16;
  localparam int VISC_FRAC = 16;
  localparam int SCALE_SHIFT = 2 * WAVE_FRAC + VISC_FRAC;
  localparam logic [VISC_W-1:0] VISC_RESET = 32'd65536;
  localparam logic [GPC_W-1:0] GPC_RESET = 31'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VISCOSITY   = 2'd0,
    CFG_GRID_POINTS = 2'd1,
    CFG_IMMEDIATE   = 2'd2
  } cfg_reg_t;
endpackage

@@ src/osn_mul.sv @@
module osn_mul #(
  parameter int AW = 24,
  parameter int BW = 32
) (
  input  logic               clk,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-1:0]   p
);
  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] p_ll_r;
  logic [AL+BH-1:0] p_lh_r;
  logic [AH+BL-1:0] p_hl_r;
  logic [AH+BH-1:0] p_hh_r;
  logic [PW-1:0]    p_r;
  logic [PW-1:0]    p_nxt;

  always_ff @(posedge clk) begin
    p_ll_r <= a[AL-1:0] * b[BL-1:0];
    p_lh_r <= a[AL-1:0] * b[BW-1:BL];
    p_hl_r <= a[AW-1:AL] * b[BL-1:0];
    p_hh_r <= a[AW-1:AL] * b[BW-1:BL];
    p_r    <= p_nxt;
  end

  always_comb begin
    p_nxt = (PW'(p_hh_r) << (AL + BL)) + (PW'(p_hl_r) << AL)
          + (PW'(p_lh_r) << BL) + PW'(p_ll_r);
  end

  assign p = p_r;
endmodule

@@ src/osn_dly.sv @@
module osn_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) tap_r[k] <= '0;
    end else begin
      tap_r[0] <= d;
      for (int k = 1; k < N; k++) tap_r[k] <= tap_r[k-1];
    end
  end

  assign q = tap_r[N-1];
endmodule

@@ src/osn_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// ovf flags a quotient of 2^QW or more.
module osn_div #(
  parameter int NW = 80,
  parameter int DVW = 48,
  parameter int QW = 33
) (
  input  logic           clk,
  input  logic [NW-1:0]  num,
  input  logic [DVW-1:0] den,
  output logic [QW-1:0]  quo,
  output logic           ovf
);
  localparam int CW = (NW > DVW + QW) ? NW : DVW + QW;

  logic [NW-1:0]  rem_r [QW+1];
  logic [DVW-1:0] d_r   [QW+1];
  logic [QW-1:0]  q_r   [QW+1];
  logic           ovf_r [QW+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    d_r[0]   <= den;
    q_r[0]   <= '0;
    ovf_r[0] <= CW'(num) >= (CW'(den) << QW);
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int SH = QW - k;
    logic [CW-1:0] dsh;
    logic [CW-1:0] diff;
    logic          ge;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    always_comb begin
      dsh     = CW'(d_r[k-1]) << SH;
      ge      = CW'(rem_r[k-1]) >= dsh;
      diff    = CW'(rem_r[k-1]) - dsh;
      rem_nxt = ge ? diff[NW-1:0] : rem_r[k-1];
      q_nxt   = q_r[k-1];
      q_nxt[SH] = ge;
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      d_r[k]   <= d_r[k-1];
      q_r[k]   <= q_nxt;
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];
endmodule

@@ src/oseen_tensor_apply.sv @@
// Oseen tensor multiply per Fourier grid point. Fully pipelined: one point
// may be started every cycle (busy stays low) and its velocity appears on
// the out_ ports, marked by out_valid for one cycle. Most of the delay to the
// result lies in the two bit-per-stage divider pipelines (projection by q^2,
// then scaling by q^2 times the viscosity, or times viscosity and grid point
// count when the immediate flag is set). Results cannot be held off: the receiver
// must take each one in the cycle it is shown. Configuration writes take
// effect for points started after the write, and should be made only while
// no point is in flight.
`include "assert_macros.svh"

module oseen_tensor_apply #(
  parameter int DATA_WIDTH = osn_pkg::DATA_WIDTH_DEF,
  parameter int WAVE_WIDTH = osn_pkg::WAVE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [WAVE_WIDTH-1:0]  in_wave_x,
  input  logic signed [WAVE_WIDTH-1:0]  in_wave_y,
  input  logic signed [WAVE_WIDTH-1:0]  in_wave_z,
  input  logic signed [DATA_WIDTH-1:0]  in_force_x_re,
  input  logic signed [DATA_WIDTH-1:0]  in_force_x_im,
  input  logic signed [DATA_WIDTH-1:0]  in_force_y_re,
  input  logic signed [DATA_WIDTH-1:0]  in_force_y_im,
  input  logic signed [DATA_WIDTH-1:0]  in_force_z_re,
  input  logic signed [DATA_WIDTH-1:0]  in_force_z_im,
  output logic                          out_valid,
  output logic signed [DATA_WIDTH-1:0]  out_vel_x_re,
  output logic signed [DATA_WIDTH-1:0]  out_vel_x_im,
  output logic signed [DATA_WIDTH-1:0]  out_vel_y_re,
  output logic signed [DATA_WIDTH-1:0]  out_vel_y_im,
  output logic signed [DATA_WIDTH-1:0]  out_vel_z_re,
  output logic signed [DATA_WIDTH-1:0]  out_vel_z_im,
  output logic                          out_saturated,
  input  logic                          cfg_we,
  input  logic [osn_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [osn_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  localparam int DW   = DATA_WIDTH;
  localparam int WW   = WAVE_WIDTH;
  localparam int QFW  = WW + DW;
  localparam int SW   = QFW + 3;
  localparam int SMW  = QFW;
  localparam int Q2W  = 2 * WW;
  localparam int N1W  = WW + SMW;
  localparam int T1W  = DW + 1;
  localparam int PSW  = DW + 3;
  localparam int PMW  = DW + 2;
  localparam int DDW  = Q2W + osn_pkg::DEN_W;
  localparam int N2W  = PMW + osn_pkg::SCALE_SHIFT;
  localparam int L1   = T1W + 1;
  localparam int L2   = DW + 1;
  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  // configuration
  logic [osn_pkg::VISC_W-1:0] visc_r;
  logic [osn_pkg::GPC_W-1:0]  gpc_r;
  logic                       imm_r;
  logic [osn_pkg::DEN_W-1:0]  den_r;
  logic [osn_pkg::DEN_W-1:0]  den_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visc_r <= osn_pkg::VISC_RESET;
      gpc_r  <= osn_pkg::GPC_RESET;
      imm_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (osn_pkg::cfg_reg_t'(cfg_addr))
        osn_pkg::CFG_VISCOSITY:   visc_r <= cfg_wdata[osn_pkg::VISC_W-1:0];
        osn_pkg::CFG_GRID_POINTS: gpc_r  <= cfg_wdata[osn_pkg::GPC_W-1:0];
        osn_pkg::CFG_IMMEDIATE:   imm_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    den_nxt = imm_r ? osn_pkg::DEN_W'(visc_r) * osn_pkg::DEN_W'(gpc_r)
                    : osn_pkg::DEN_W'(visc_r);
  end

  always_ff @(posedge clk) den_r <= den_nxt;

  assign busy = 1'b0;

  // input stage
  logic [2:0][WW-1:0] wave_r;
  logic [5:0][DW-1:0] force_r;
  logic               v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy;
    wave_r  <= {in_wave_z, in_wave_y, in_wave_x};
    force_r <= {in_force_z_im, in_force_z_re, in_force_y_im, in_force_y_re,
                in_force_x_im, in_force_x_re};
  end

  logic [2:0][WW-1:0] qm0;
  logic [2:0]         qn0;
  logic [5:0][DW-1:0] fm0;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qn0[c] = wave_r[c][WW-1];
      qm0[c] = qn0[c] ? WW'(-wave_r[c]) : wave_r[c];
    end
    for (int l = 0; l < 6; l++) begin
      fm0[l] = force_r[l][DW-1] ? DW'(-force_r[l]) : force_r[l];
    end
  end

  // products q_c * f_c and q_c^2
  logic [5:0][QFW-1:0] qf2;
  logic [2:0][Q2W-1:0] sq2;

  for (genvar l = 0; l < 6; l++) begin : g_qf
    osn_mul #(.AW(WW), .BW(DW)) u_mul (
      .clk(clk), .a(qm0[l/2]), .b(fm0[l]), .p(qf2[l])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_sq
    osn_mul #(.AW(WW), .BW(WW)) u_mul (
      .clk(clk), .a(qm0[c]), .b(qm0[c]), .p(sq2[c])
    );
  end

  logic [5:0][DW-1:0] f2;
  logic [2:0][WW-1:0] qm2;
  logic [2:0]         qn2;
  logic               v2;

  osn_dly #(.W(6*DW + 3*WW + 4), .N(2)) u_dly_a (
    .clk(clk), .rst_n(rst_n),
    .d({force_r, qm0, qn0, v0_r}),
    .q({f2, qm2, qn2, v2})
  );

  // dot product and q^2
  logic signed [1:0][SW-1:0] s_nxt;
  logic [Q2W-1:0]            q2_nxt;
  logic [1:0][SW-1:0]        s3_r;
  logic [Q2W-1:0]            q2_3_r;
  logic [2:0][WW-1:0]        qm3_r;
  logic [2:0]                qn3_r;
  logic [5:0][DW-1:0]        f3_r;
  logic                      v3_r;

  always_comb begin
    logic [SW-1:0] term;
    term = '0;
    for (int p = 0; p < 2; p++) begin
      s_nxt[p] = '0;
      for (int c = 0; c < 3; c++) begin
        term = SW'(qf2[2*c+p]);
        if (qn2[c] ^ f2[2*c+p][DW-1]) term = -term;
        s_nxt[p] = s_nxt[p] + term;
      end
    end
    q2_nxt = Q2W'(sq2[0] + sq2[1] + sq2[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2;
    s3_r   <= s_nxt;
    q2_3_r <= q2_nxt;
    qm3_r  <= qm2;
    qn3_r  <= qn2;
    f3_r   <= f2;
  end

  // magnitude of the dot product
  logic [1:0][SMW-1:0] sm4_r;
  logic [1:0]          sn4_r;
  logic [Q2W-1:0]      q2_4_r;
  logic [2:0][WW-1:0]  qm4_r;
  logic [2:0]          qn4_r;
  logic [5:0][DW-1:0]  f4_r;
  logic                v4_r;
  logic [1:0][SW-1:0]  sabs;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      sabs[p] = s3_r[p][SW-1] ? -s3_r[p] : s3_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    for (int p = 0; p < 2; p++) begin
      sm4_r[p] <= sabs[p][SMW-1:0];
      sn4_r[p] <= s3_r[p][SW-1];
    end
    q2_4_r <= q2_3_r;
    qm4_r  <= qm3_r;
    qn4_r  <= qn3_r;
    f4_r   <= f3_r;
  end

  // |q_c| * |s| and q^2 * d
  logic [5:0][N1W-1:0] n1;
  logic [5:0]          tn4;
  logic [DDW-1:0]      dd6;

  for (genvar l = 0; l < 6; l++) begin : g_n1
    osn_mul #(.AW(WW), .BW(SMW)) u_mul (
      .clk(clk), .a(qm4_r[l/2]), .b(sm4_r[l%2]), .p(n1[l])
    );
    assign tn4[l] = qn4_r[l/2] ^ sn4_r[l%2];
  end

  osn_mul #(.AW(Q2W), .BW(osn_pkg::DEN_W)) u_mul_dd (
    .clk(clk), .a(q2_4_r), .b(den_r), .p(dd6)
  );

  logic [5:0][DW-1:0] f6;
  logic [5:0]         tn6;
  logic [Q2W-1:0]     q2_6;
  logic               v6;
  logic               z6;

  osn_dly #(.W(6*DW + 6 + Q2W + 1), .N(2)) u_dly_b (
    .clk(clk), .rst_n(rst_n),
    .d({f4_r, tn4, q2_4_r, v4_r}),
    .q({f6, tn6, q2_6, v6})
  );

  assign z6 = (q2_6 == '0);

  // projection term t_c = q_c * s / q^2
  logic [5:0][T1W-1:0] t7;

  for (genvar l = 0; l < 6; l++) begin : g_div1
    osn_div #(.NW(N1W), .DVW(Q2W), .QW(T1W)) u_div (
      .clk(clk), .num(n1[l]), .den(q2_6), .quo(t7[l]), .ovf()
    );
  end

  logic [5:0][DW-1:0] f7;
  logic [5:0]         tn7;
  logic               v7;
  logic               z7;
  logic [DDW-1:0]     dd7;

  osn_dly #(.W(6*DW + 6 + 2 + DDW), .N(L1)) u_dly_c (
    .clk(clk), .rst_n(rst_n),
    .d({f6, tn6, v6, z6, dd6}),
    .q({f7, tn7, v7, z7, dd7})
  );

  // projected force
  logic [5:0][PSW-1:0] p_nxt;
  logic [5:0][PMW-1:0] pm8_r;
  logic [5:0]          pn8_r;
  logic [5:0]          pz8_r;
  logic                v8_r;
  logic                z8_r;
  logic [DDW-1:0]      dd8_r;

  always_comb begin
    logic [PSW-1:0] ts;
    ts = '0;
    for (int l = 0; l < 6; l++) begin
      ts = PSW'(t7[l]);
      if (tn7[l]) ts = -ts;
      p_nxt[l] = PSW'($signed(f7[l])) - ts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else        v8_r <= v7;
    for (int l = 0; l < 6; l++) begin
      pn8_r[l] <= p_nxt[l][PSW-1];
      pz8_r[l] <= (p_nxt[l] == '0);
      pm8_r[l] <= p_nxt[l][PSW-1] ? PMW'(-p_nxt[l]) : p_nxt[l][PMW-1:0];
    end
    z8_r  <= z7;
    dd8_r <= dd7;
  end

  // scaling by 1 / (q^2 * d)
  logic [5:0][DW-1:0] quo9;
  logic [5:0]         ovf9;

  for (genvar l = 0; l < 6; l++) begin : g_div2
    osn_div #(.NW(N2W), .DVW(DDW), .QW(DW)) u_div (
      .clk(clk),
      .num({pm8_r[l], {osn_pkg::SCALE_SHIFT{1'b0}}}),
      .den(dd8_r), .quo(quo9[l]), .ovf(ovf9[l])
    );
  end

  logic [5:0] pn9;
  logic [5:0] pz9;
  logic       v9;
  logic       z9;

  osn_dly #(.W(14), .N(L2)) u_dly_d (
    .clk(clk), .rst_n(rst_n),
    .d({pn8_r, pz8_r, v8_r, z8_r}),
    .q({pn9, pz9, v9, z9})
  );

  // saturation and sign
  logic [5:0][DW-1:0] vel_nxt;
  logic               sat_nxt;
  logic [5:0][DW-1:0] vel_r;
  logic               sat_r;
  logic               ov_r;

  always_comb begin
    logic [DW-1:0] lim;
    logic [DW-1:0] m;
    logic          clip;
    lim = '0;
    m = '0;
    clip = 1'b0;
    sat_nxt = 1'b0;
    for (int l = 0; l < 6; l++) begin
      lim  = pn9[l] ? SMIN : SMAX;
      clip = ovf9[l] || (quo9[l] > lim);
      m    = clip ? lim : quo9[l];
      if (z9 || pz9[l]) begin
        m = '0;
        clip = 1'b0;
      end
      vel_nxt[l] = pn9[l] ? DW'(-m) : m;
      sat_nxt = sat_nxt | clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= v9;
    vel_r <= vel_nxt;
    sat_r <= sat_nxt;
  end

  assign out_valid     = ov_r;
  assign out_vel_x_re  = vel_r[0];
  assign out_vel_x_im  = vel_r[1];
  assign out_vel_y_re  = vel_r[2];
  assign out_vel_y_im  = vel_r[3];
  assign out_vel_z_re  = vel_r[4];
  assign out_vel_z_im  = vel_r[5];
  assign out_saturated = sat_r;

  logic out_at_lim;

  always_comb begin
    out_at_lim = 1'b0;
    for (int l = 0; l < 6; l++) begin
      out_at_lim = out_at_lim || (vel_r[l] == SMAX) || (vel_r[l] == SMIN);
    end
  end

  `OSN_ASSERT(a_sat_hits_limit, clk, rst_n, (out_valid && out_saturated) |-> out_at_lim)
  `OSN_ASSERT(a_div2_align, clk, rst_n, out_valid |-> $past(v8_r, L2 + 1))
  `OSN_ASSERT_NORST(a_never_busy, clk, !busy)
endmodule
